// ----- rtl/core/ugsb_pkg.sv -----
package ugsb_pkg;

  localparam int COORD_W = 24;
  localparam int GRID_W  = 11;
  localparam int NUM_W   = COORD_W + 1;
  localparam int DEN_W   = COORD_W;
  localparam int OUT_ID_W = 16;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS = 2'd2;

  localparam logic [COORD_W-1:0] CELL_SIZE_RST = 24'd2560;
  localparam logic [GRID_W-1:0]  GRID_RST      = 11'd32;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- rtl/core/uniform_grid_spatial_binning_top.sv -----
// Uniform grid broad phase: buckets of ids per cell, for neighbour search.
// Input channel (in_valid/in_stall) carries one command: clear, insert or
// query. One command is worked on at a time; in_stall is high until its
// last result has been handed to the output register.
// Output channel (out_valid/out_stall) carries results; last marks the
// final result of a command. Clear and insert give one result, a query one
// per id found (up to MAX_OUT), or a single empty result.
// One shared restoring divider does all the arithmetic: an insert needs
// three divisions, a query up to five, after which the query walks every
// covered cell and reads out each id in it. Clear wipes one cell-count
// entry per cycle.
// Reset: registers take their defaults and a sweep zeroes all MAX_CELLS
// cell counts; no command is taken meanwhile. Config writes are
// taken at any time on cfg_we.
// A stalled receiver holds the result register; the walk waits for it.
module uniform_grid_spatial_binning_top #(
  parameter int MAX_CELLS = 1024,
  parameter int CELL_CAP  = 8,
  parameter int ID_BITS   = 16,
  parameter int MAX_OUT   = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [ugsb_pkg::COORD_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      action,
  input  logic [15:0]                     item_id,
  input  logic [ugsb_pkg::COORD_W-1:0]    x_pos,
  input  logic [ugsb_pkg::COORD_W-1:0]    y_pos,
  input  logic [ugsb_pkg::COORD_W-1:0]    radius,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ugsb_pkg::OUT_ID_W-1:0]   candidate_id,
  output logic [1:0]                      status,
  output logic                            last
);
  import ugsb_pkg::*;

  localparam int IDX_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int BDEPTH = MAX_CELLS * CELL_CAP;
  localparam int BA_W   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int CNT_W  = $clog2(CELL_CAP + 1);
  localparam int EM_W   = $clog2(MAX_OUT + 1);
  localparam int PROD_W = 2 * GRID_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_DIVGO = 4'd2;
  localparam logic [3:0] S_DIVW  = 4'd3;
  localparam logic [3:0] S_IDX   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_ONE   = 4'd7;
  localparam logic [3:0] S_QCNT  = 4'd8;
  localparam logic [3:0] S_QB    = 4'd9;
  localparam logic [3:0] S_QBD   = 4'd10;
  localparam logic [3:0] S_QFIN  = 4'd11;

  logic [COORD_W-1:0] cell_size;
  logic [GRID_W-1:0]  grid_cols;
  logic [GRID_W-1:0]  grid_rows;

  logic [3:0]         state;
  logic [2:0]         ph;
  logic               clr_reply;
  logic [IDX_W-1:0]   clr_addr;
  logic [1:0]         act;
  logic [ID_BITS-1:0] id_r;
  logic [COORD_W-1:0] x_r, y_r, r_r;
  logic [GRID_W-1:0]  rows_e;
  logic [GRID_W-1:0]  left_r, right_r, top_r;
  logic [GRID_W-1:0]  cy_bottom;
  logic [GRID_W-1:0]  cx, cy;
  logic [IDX_W-1:0]   idx_r;
  logic [CNT_W-1:0]   n_r, e_r;
  logic [EM_W-1:0]    emitted;
  logic               pend_v;
  logic [ID_BITS-1:0] pend_id;
  logic [1:0]         pend_st;
  logic [1:0]         one_st;

  logic               o_valid;
  logic [OUT_ID_W-1:0] o_id;
  logic [1:0]         o_st;
  logic               o_last;

  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [GRID_W-1:0]  c0, cols_e, rows_raw, lim, cell_q;
  logic [COORD_W-1:0] cs_e;
  logic               skip, can_emit, ins, at_end, accept;

  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rd;
  logic               bk_we;
  logic [BA_W-1:0]    bk_waddr, bk_raddr;
  logic [ID_BITS-1:0] bk_rd;

  assign c0       = (grid_cols == '0) ? GRID_W'(1) : grid_cols;
  assign cols_e   = (32'(c0) > MAX_CELLS) ? GRID_W'(MAX_CELLS) : c0;
  assign rows_raw = (grid_rows == '0) ? GRID_W'(1) : grid_rows;
  assign cs_e     = (cell_size == '0) ? COORD_W'(1) : cell_size;
  assign ins      = (act == ACT_INSERT);
  assign can_emit = !o_valid || !out_stall;
  assign at_end   = (cx == right_r) && (cy == cy_bottom);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    dreq.start = (state == S_DIVGO) && !skip;
    dreq.den   = (ph == 3'd0) ? COORD_W'(cols_e) : cs_e;
    case (ph)
      3'd0:    dreq.num = NUM_W'(MAX_CELLS);
      3'd1:    dreq.num = NUM_W'(x_r) - NUM_W'(r_r);
      3'd2:    dreq.num = NUM_W'(x_r) + NUM_W'(r_r);
      3'd3:    dreq.num = NUM_W'(y_r) - NUM_W'(r_r);
      default: dreq.num = NUM_W'(y_r) + NUM_W'(r_r);
    endcase
  end

  assign skip = ((ph == 3'd1) && (ins || x_r <= r_r)) ||
                ((ph == 3'd3) && (ins || y_r <= r_r));

  assign lim    = (ph <= 3'd2) ? cols_e : rows_e;
  assign cell_q = (drsp.quo > NUM_W'(lim) - NUM_W'(1)) ? lim - GRID_W'(1)
                                                       : drsp.quo[GRID_W-1:0];

  ugsb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx_r;
    cnt_wdata = CNT_W'(cnt_rd + 1'b1);
    bk_we     = 1'b0;
    if (state == S_CLR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end else if (state == S_INS && 32'(cnt_rd) < CELL_CAP) begin
      cnt_we = 1'b1;
      bk_we  = 1'b1;
    end
  end

  assign bk_waddr = BA_W'(BA_W'(idx_r) * BA_W'(CELL_CAP) + BA_W'(cnt_rd));
  assign bk_raddr = BA_W'(BA_W'(idx_r) * BA_W'(CELL_CAP) + BA_W'(e_r));

  ugsb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS), .AW(IDX_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (idx_r),
    .rdata (cnt_rd)
  );

  ugsb_ram #(.WIDTH(ID_BITS), .DEPTH(BDEPTH), .AW(BA_W)) u_bucket_ram (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (id_r),
    .raddr (bk_raddr),
    .rdata (bk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CELL_SIZE_RST;
      grid_cols <= GRID_RST;
      grid_rows <= GRID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_SIZE: cell_size <= cfg_data;
        REG_GRID_COLS: grid_cols <= cfg_data[GRID_W-1:0];
        REG_GRID_ROWS: grid_rows <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_reply <= 1'b0;
      clr_addr  <= '0;
      ph        <= '0;
      pend_v    <= 1'b0;
      emitted   <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (!out_stall) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            act     <= action;
            id_r    <= ID_BITS'(item_id);
            x_r     <= x_pos;
            y_r     <= y_pos;
            r_r     <= (action == ACT_INSERT) ? '0 : radius;
            ph      <= '0;
            pend_v  <= 1'b0;
            pend_st <= ST_OK;
            emitted <= '0;
            case (action)
              ACT_CLEAR: begin
                state     <= S_CLR;
                clr_reply <= 1'b1;
                clr_addr  <= '0;
              end
              ACT_INSERT, ACT_QUERY: state <= S_DIVGO;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(MAX_CELLS - 1)) begin
            one_st <= ST_OK;
            state  <= clr_reply ? S_ONE : S_IDLE;
          end
        end
        S_DIVGO: begin
          if (skip) begin
            if (ph == 3'd1) left_r <= '0;
            else            top_r  <= '0;
            ph <= ph + 1'b1;
          end else begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (drsp.done) begin
            state <= (ph >= 3'd4) ? S_IDX : S_DIVGO;
            ph    <= ph + 1'b1;
            case (ph)
              3'd0: rows_e <= (NUM_W'(rows_raw) > drsp.quo) ? drsp.quo[GRID_W-1:0]
                                                           : rows_raw;
              3'd1: left_r  <= cell_q;
              3'd2: right_r <= cell_q;
              3'd3: top_r   <= cell_q;
              default: begin
                cy_bottom <= cell_q;
                cx        <= ins ? right_r : left_r;
                cy        <= ins ? cell_q : top_r;
              end
            endcase
          end
        end
        S_IDX: begin
          idx_r <= IDX_W'(PROD_W'(cy) * PROD_W'(cols_e) + PROD_W'(cx));
          state <= S_RD;
        end
        S_RD: state <= ins ? S_INS : S_QCNT;
        S_INS: begin
          one_st <= (32'(cnt_rd) < CELL_CAP) ? ST_OK : ST_FULL;
          state  <= S_ONE;
        end
        S_ONE: begin
          if (can_emit) begin
            o_valid <= 1'b1;
            o_id    <= '0;
            o_st    <= one_st;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_QCNT: begin
          n_r <= cnt_rd;
          e_r <= '0;
          if (cnt_rd != '0) begin
            state <= S_QB;
          end else if (at_end) begin
            state <= S_QFIN;
          end else begin
            state <= S_IDX;
            if (cx != right_r) begin
              cx <= cx + 1'b1;
            end else begin
              cx <= left_r;
              cy <= cy + 1'b1;
            end
          end
        end
        S_QB: state <= S_QBD;
        S_QBD: begin
          if (pend_v && 32'(emitted) == MAX_OUT) begin
            pend_st <= ST_TRUNC;
            state   <= S_QFIN;
          end else if (!pend_v || can_emit) begin
            if (pend_v) begin
              o_valid <= 1'b1;
              o_id    <= OUT_ID_W'(pend_id);
              o_st    <= ST_OK;
              o_last  <= 1'b0;
            end
            pend_v  <= 1'b1;
            pend_id <= bk_rd;
            emitted <= emitted + 1'b1;
            if (CNT_W'(e_r + 1'b1) != n_r) begin
              e_r   <= e_r + 1'b1;
              state <= S_QB;
            end else if (at_end) begin
              state <= S_QFIN;
            end else begin
              state <= S_IDX;
              if (cx != right_r) begin
                cx <= cx + 1'b1;
              end else begin
                cx <= left_r;
                cy <= cy + 1'b1;
              end
            end
          end
        end
        S_QFIN: begin
          if (can_emit) begin
            o_valid <= 1'b1;
            o_id    <= pend_v ? OUT_ID_W'(pend_id) : '0;
            o_st    <= pend_v ? pend_st : ST_EMPTY;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = o_valid;
  assign candidate_id = o_id;
  assign status       = o_st;
  assign last         = o_last;

endmodule

// ----- rtl/core/ugsb_ram.sv -----
module ugsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ugsb_div.sv -----
module ugsb_div (
  input  logic                clk,
  input  logic                rst,
  input  ugsb_pkg::div_req_t  req,
  output ugsb_pkg::div_rsp_t  rsp
);
  import ugsb_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] n_sh;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic             done;
  logic [DEN_W:0]   trial;

  assign trial = {rem, n_sh[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W);
        n_sh  <= req.num;
        den_r <= req.den;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den_r}) begin
          rem <= DEN_W'(trial - {1'b0, den_r});
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        n_sh <= {n_sh[NUM_W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

// ----- rtl/core/ugsb_chk.sv -----
module ugsb_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    action,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ugsb_pkg::OUT_ID_W-1:0] candidate_id,
  input logic [1:0]                    status,
  input logic                          last
);
  import ugsb_pkg::*;

  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_EMPTY || status == ST_TRUNC)
      |-> last)
    else $error("error status without last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> candidate_id == '0)
    else $error("empty result with non-zero id");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action != ACT_NONE |=> in_stall)
    else $error("input taken while a command is in progress");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(candidate_id) &&
      $stable(status) && $stable(last))
    else $error("stalled result changed");

endmodule

bind uniform_grid_spatial_binning_top ugsb_chk u_chk (.*);

// ----- tb/uniform_grid_spatial_binning_top_tb.sv -----
`timescale 1ns / 100ps

module uniform_grid_spatial_binning_top_tb;
  import ugsb_pkg::*;

  localparam int MAX_CELLS = 1024;
  localparam int CELL_CAP  = 8;
  localparam int MAX_OUT   = 64;
  localparam int WATCHDOG  = 20000;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] id;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] r;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cand;
    logic [1:0]  st;
    logic        lst;
  } hit_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  chk;
    hit_t  hit;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_CELL_SIZE;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_CLEAR;
  logic [15:0] item_id = '0;
  logic [23:0] x_pos = '0, y_pos = '0, radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] candidate_id;
  logic [1:0] status;
  logic last;

  uniform_grid_spatial_binning_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // grid shadow
  logic [23:0] g_cell_size;
  logic [10:0] g_cols, g_rows;
  int unsigned g_count [MAX_CELLS];
  logic [15:0] g_bucket [MAX_CELLS*CELL_CAP];

  hit_t expected_hits[$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit timed_out = 0;
  bit hold_receiver = 0;
  int n_query = 0, n_insert = 0, n_clear = 0, n_full = 0, n_trunc = 0, n_empty = 0;

  function automatic int unsigned grid_w();
    int unsigned c;
    c = (g_cols == 0) ? 1 : g_cols;
    if (c > MAX_CELLS) c = MAX_CELLS;
    return c;
  endfunction

  function automatic int unsigned grid_h(int unsigned c);
    int unsigned r;
    r = (g_rows == 0) ? 1 : g_rows;
    if (r > MAX_CELLS / c) r = MAX_CELLS / c;
    return r;
  endfunction

  function automatic int unsigned cell_of(longint unsigned coord, int unsigned lim);
    longint unsigned cs, q;
    cs = (g_cell_size == 0) ? 1 : g_cell_size;
    q = coord / cs;
    return (q > lim - 1) ? lim - 1 : int'(q);
  endfunction

  task automatic push_hit(logic [15:0] c, logic [1:0] s, logic l);
    hit_t h;
    h.cand = c;
    h.st = s;
    h.lst = l;
    expected_hits.insert(expected_hits.size(), h);
  endtask

  task automatic predict_bins(cmd_t c);
    int unsigned cols, rows, idx, lo_x, hi_x, lo_y, hi_y, n;
    int emitted;
    bit trunc;
    cols = grid_w();
    rows = grid_h(cols);
    case (c.act)
      ACT_CLEAR: begin
        foreach (g_count[i]) g_count[i] = 0;
        push_hit('0, ST_OK, 1'b1);
        n_clear++;
      end
      ACT_INSERT: begin
        idx = cell_of(c.y, rows) * cols + cell_of(c.x, cols);
        n = g_count[idx];
        n_insert++;
        if (n >= CELL_CAP) begin
          push_hit('0, ST_FULL, 1'b1);
          n_full++;
        end else begin
          g_bucket[idx*CELL_CAP + n] = c.id;
          g_count[idx] = n + 1;
          push_hit('0, ST_OK, 1'b1);
        end
      end
      ACT_QUERY: begin
        n_query++;
        lo_x = (c.x > c.r) ? cell_of(c.x - c.r, cols) : 0;
        hi_x = cell_of(longint'(c.x) + c.r, cols);
        lo_y = (c.y > c.r) ? cell_of(c.y - c.r, rows) : 0;
        hi_y = cell_of(longint'(c.y) + c.r, rows);
        emitted = 0;
        trunc = 0;
        for (int unsigned cy = lo_y; cy <= hi_y && !trunc; cy++)
          for (int unsigned cx = lo_x; cx <= hi_x && !trunc; cx++) begin
            idx = cy * cols + cx;
            for (int unsigned e = 0; e < g_count[idx]; e++) begin
              if (emitted >= MAX_OUT) begin
                trunc = 1;
                break;
              end
              push_hit(g_bucket[idx*CELL_CAP + e], ST_OK, 1'b0);
              emitted++;
            end
          end
        if (emitted == 0) begin
          push_hit('0, ST_EMPTY, 1'b1);
          n_empty++;
        end else begin
          expected_hits[expected_hits.size() - 1].lst = 1'b1;
          if (trunc) begin
            expected_hits[expected_hits.size() - 1].st = ST_TRUNC;
            n_trunc++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // valid stays high into the next transfer when no gap is drawn
  task automatic send_raw(cmd_t c);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= c.act;
    item_id <= c.id;
    x_pos <= c.x;
    y_pos <= c.y;
    radius <= c.r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_cmd(cmd_t c);
    send_raw(c);
    predict_bins(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (MAX_CELLS + 200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CELL_SIZE: g_cell_size = val;
      REG_GRID_COLS: g_cols = val[10:0];
      default: g_rows = val[10:0];
    endcase
    @(posedge clk);
  endtask

  function automatic cmd_t mk(logic [1:0] a, logic [15:0] id, logic [23:0] x,
                               logic [23:0] y, logic [23:0] r);
    cmd_t c;
    c.act = a; c.id = id; c.x = x; c.y = y; c.r = r;
    return c;
  endfunction

  function automatic cmd_t rand_cmd(int unsigned span);
    cmd_t c;
    int unsigned p;
    p = $urandom_range(0, 99);
    c.act = (p < 2) ? ACT_CLEAR : (p < 4) ? ACT_NONE : (p < 65) ? ACT_INSERT : ACT_QUERY;
    c.id = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      c.x = 24'($urandom);
      c.y = 24'($urandom);
      c.r = 24'($urandom);
    end else begin
      c.x = 24'($urandom_range(0, span));
      c.y = 24'($urandom_range(0, span));
      c.r = 24'($urandom_range(0, span / 4));
    end
    return c;
  endfunction

  // result checking
  always @(posedge clk) begin
    hit_t h;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: id %0h st %0d last %0b",
                                       candidate_id, status, last);
      end else begin
        h = expected_hits.pop_front();
        if (h.cand !== candidate_id || h.st !== status || h.lst !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp id %0h st %0d last %0b, got id %0h st %0d last %0b",
                     h.cand, h.st, h.lst, candidate_id, status, last);
        end
      end
    end
  end

  // receiver: a randomly drawn wait between transfers
  always @(posedge clk) begin
    if (hold_receiver) out_stall <= 1'b1;
    else if (out_valid && !out_stall) begin
      rx_wait = $urandom_range(0, 6);
      out_stall <= (rx_wait != 0);
    end else if (out_valid && rx_wait != 0) begin
      rx_wait--;
      out_stall <= (rx_wait != 0);
    end else if (rx_wait == 0) out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("uniform_grid_spatial_binning_top regression: fail");
      $finish;
    end
  end

  row_t dir_rows[$];

  task automatic add_row(row_t rw);
    dir_rows.insert(dir_rows.size(), rw);
  endtask

  initial begin
    row_t rw;
    cmd_t c;
    g_cell_size = CELL_SIZE_RST;
    g_cols = GRID_RST;
    g_rows = GRID_RST;
    foreach (g_count[i]) g_count[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rw.chk = 1;
    rw.cmd = mk(ACT_QUERY, '0, 24'd100, 24'd100, 24'hFFFFFF);
    rw.hit = '{cand: 16'd0, st: ST_EMPTY, lst: 1'b1};
    add_row(rw);
    rw.cmd = mk(ACT_INSERT, 16'hFFFF, '0, '0, '0);
    rw.hit = '{cand: 16'd0, st: ST_OK, lst: 1'b1};
    add_row(rw);
    rw.cmd = mk(ACT_INSERT, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, '0);
    add_row(rw);
    rw.cmd = mk(ACT_INSERT, 16'h5A5A, 24'hFFFFFF, '0, 24'hFFFFFF);
    add_row(rw);
    rw.chk = 0;
    for (int i = 0; i < 8; i++) begin
      rw.cmd = mk(ACT_INSERT, 16'(16'h1000 + i), 24'd2600, 24'd2600, '0);
      add_row(rw);
    end
    rw.chk = 1;
    rw.cmd = mk(ACT_INSERT, 16'hA5A5, 24'd2600, 24'd2600, '0);
    rw.hit = '{cand: 16'd0, st: ST_FULL, lst: 1'b1};
    add_row(rw);
    rw.chk = 0;
    rw.cmd = mk(ACT_NONE, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_row(rw);
    rw.cmd = mk(ACT_QUERY, '0, 24'd2600, 24'd2600, '0);
    add_row(rw);
    rw.cmd = mk(ACT_QUERY, '0, 24'd0, 24'd0, 24'd0);
    add_row(rw);
    rw.cmd = mk(ACT_QUERY, '0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_row(rw);
    rw.cmd = mk(ACT_QUERY, '0, 24'h800000, 24'h800000, 24'hFFFFFF);
    add_row(rw);
    rw.chk = 1;
    rw.cmd = mk(ACT_CLEAR, '0, '0, '0, '0);
    rw.hit = '{cand: 16'd0, st: ST_OK, lst: 1'b1};
    add_row(rw);
    rw.cmd = mk(ACT_QUERY, '0, 24'd2600, 24'd2600, 24'd5000);
    rw.hit = '{cand: 16'd0, st: ST_EMPTY, lst: 1'b1};
    add_row(rw);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].chk) begin
        predict_bins(dir_rows[i].cmd);
        // typed expectation stands in for the predicted one
        expected_hits[expected_hits.size() - 1] = dir_rows[i].hit;
        send_raw(dir_rows[i].cmd);
      end else send_cmd(dir_rows[i].cmd);
    end
    drain();

    // long receiver hold while sender keeps offering
    fork
      begin
        hold_receiver = 1;
        repeat (400) @(posedge clk);
        hold_receiver = 0;
      end
      for (int i = 0; i < 12; i++) send_cmd(rand_cmd(24'd20000));
    join
    drain();

    // many ids in a small patch so the wide query truncates
    for (int i = 0; i < 66; i++) begin
      c = mk(ACT_INSERT, 16'($urandom), 24'($urandom_range(0, 12000)),
             24'($urandom_range(0, 12000)), '0);
      send_cmd(c);
    end
    send_cmd(mk(ACT_QUERY, '0, 24'd6000, 24'd6000, 24'd6000));
    drain();

    // zero/odd config extremes
    write_reg(REG_CELL_SIZE, 24'd0);
    write_reg(REG_GRID_COLS, 24'd0);
    write_reg(REG_GRID_ROWS, 24'd0);
    for (int i = 0; i < 20; i++) send_cmd(rand_cmd(24'd50));
    drain();

    write_reg(REG_CELL_SIZE, 24'hFFFFFF);
    write_reg(REG_GRID_COLS, 24'd2047);
    write_reg(REG_GRID_ROWS, 24'd1024);
    for (int i = 0; i < 20; i++) send_cmd(rand_cmd(24'hFFFFFF));
    drain();

    write_reg(REG_CELL_SIZE, 24'd1);
    write_reg(REG_GRID_COLS, 24'd1024);
    write_reg(REG_GRID_ROWS, 24'd1);
    for (int i = 0; i < 20; i++) send_cmd(rand_cmd(24'd1200));
    drain();

    write_reg(REG_CELL_SIZE, 24'd300);
    write_reg(REG_GRID_COLS, 24'd7);
    write_reg(REG_GRID_ROWS, 24'd5);
    for (int i = 0; i < 11; i++) send_cmd(rand_cmd(24'd2400));
    drain();

    $display("covered %0d clears, %0d inserts (%0d full), %0d queries", n_clear, n_insert,
             n_full, n_query);
    $display("%0d empty and %0d truncated queries, %0d results checked", n_empty, n_trunc,
             results_seen);
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("uniform_grid_spatial_binning_top regression: pass");
    else
      $display("uniform_grid_spatial_binning_top regression: fail");
    $finish;
  end

endmodule
